// ===== src/iteu_pkg.sv =====
`default_nettype none

package iteu_pkg;

   localparam int unsigned OP_W   = 4;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned IMM_W  = 16;

   // Sequential pc step
   localparam logic [WORD_W-1:0] PC_STEP = 32'd4;

   typedef enum logic [OP_W-1:0] {
      OP_ADDI  = 4'd0,
      OP_ADDIU = 4'd1,
      OP_ANDI  = 4'd2,
      OP_ORI   = 4'd3,
      OP_XORI  = 4'd4,
      OP_LUI   = 4'd5,
      OP_SLTI  = 4'd6,
      OP_SLTIU = 4'd7,
      OP_BEQ   = 4'd8,
      OP_BNE   = 4'd9,
      OP_BGEZ  = 4'd10,
      OP_BGTZ  = 4'd11,
      OP_BLEZ  = 4'd12,
      OP_BLTZ  = 4'd13,
      OP_MEM   = 4'd14
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          req_type;
      logic signed [WORD_W-1:0] rs_value;
      logic signed [WORD_W-1:0] rt_value;
      logic [IMM_W-1:0]         immediate;
      logic [WORD_W-1:0]        pc_value;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_value;
      logic              write_result;
      logic              overflow;
      logic              branch_taken;
      logic [WORD_W-1:0] next_pc;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== src/iteu_req_if.sv =====
`default_nettype none

interface iteu_req_if import iteu_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          req_type;
   logic signed [WORD_W-1:0] rs_value;
   logic signed [WORD_W-1:0] rt_value;
   logic [IMM_W-1:0]         immediate;
   logic [WORD_W-1:0]        pc_value;

   modport source (output valid, req_type, rs_value, rt_value, immediate, pc_value,
                   input ready);
   modport sink   (input valid, req_type, rs_value, rt_value, immediate, pc_value,
                   output ready);
endinterface

`default_nettype wire

// ===== src/iteu_rsp_if.sv =====
`default_nettype none

interface iteu_rsp_if import iteu_pkg::*;;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_value;
   logic              write_result;
   logic              overflow;
   logic              branch_taken;
   logic [WORD_W-1:0] next_pc;

   modport source (output valid, result_value, write_result, overflow, branch_taken,
                   next_pc, input ready);
   modport sink   (input valid, result_value, write_result, overflow, branch_taken,
                   next_pc, output ready);
endinterface

`default_nettype wire

// ===== src/iteu_alu.sv =====
`default_nettype none

module iteu_alu import iteu_pkg::*; (
   input  wire req_payload_type req,
   output rsp_payload_type      rsp
);

   logic [WORD_W-1:0] rs_u;
   logic [WORD_W-1:0] simm;
   logic [WORD_W-1:0] zimm;
   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] seq_pc;
   logic [WORD_W-1:0] target;
   logic              add_ovf;
   logic              rs_neg;
   logic              rs_zero;
   logic              take;

   assign rs_u    = req.rs_value;
   assign simm    = {{(WORD_W-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
   assign zimm    = {{(WORD_W-IMM_W){1'b0}}, req.immediate};
   assign sum     = rs_u + simm;
   assign seq_pc  = req.pc_value + PC_STEP;
   assign target  = seq_pc + {simm[WORD_W-3:0], 2'b00};
   // operands agree in sign, sum does not
   assign add_ovf = (rs_u[WORD_W-1] == simm[WORD_W-1]) && (sum[WORD_W-1] != rs_u[WORD_W-1]);
   assign rs_neg  = rs_u[WORD_W-1];
   assign rs_zero = (rs_u == '0);

   always_comb begin
      rsp.result_value = '0;
      rsp.write_result = 1'b0;
      rsp.overflow     = 1'b0;
      take             = 1'b0;
      case (op_type'(req.req_type))
         OP_ADDI: begin
            if (add_ovf) begin
               rsp.overflow = 1'b1;
            end else begin
               rsp.result_value = sum;
               rsp.write_result = 1'b1;
            end
         end
         OP_ADDIU: begin
            rsp.result_value = sum;
            rsp.write_result = 1'b1;
         end
         OP_ANDI: begin
            rsp.result_value = rs_u & zimm;
            rsp.write_result = 1'b1;
         end
         OP_ORI: begin
            rsp.result_value = rs_u | zimm;
            rsp.write_result = 1'b1;
         end
         OP_XORI: begin
            rsp.result_value = rs_u ^ zimm;
            rsp.write_result = 1'b1;
         end
         OP_LUI: begin
            rsp.result_value = {req.immediate, {(WORD_W-IMM_W){1'b0}}};
            rsp.write_result = 1'b1;
         end
         OP_SLTI: begin
            rsp.result_value = {{(WORD_W-1){1'b0}}, ($signed(rs_u) < $signed(simm))};
            rsp.write_result = 1'b1;
         end
         OP_SLTIU: begin
            rsp.result_value = {{(WORD_W-1){1'b0}}, (rs_u < simm)};
            rsp.write_result = 1'b1;
         end
         OP_BEQ:  take = (req.rs_value == req.rt_value);
         OP_BNE:  take = (req.rs_value != req.rt_value);
         OP_BGEZ: take = !rs_neg;
         OP_BGTZ: take = !rs_neg && !rs_zero;
         OP_BLEZ: take = rs_neg || rs_zero;
         OP_BLTZ: take = rs_neg;
         OP_MEM:  rsp.result_value = sum;
         default: begin
         end
      endcase
      rsp.branch_taken = take;
      rsp.next_pc      = take ? target : seq_pc;
   end

endmodule

`default_nettype wire

// ===== src/itype_execute_unit.sv =====
// itype_execute_unit: execute stage for 32-bit I-type instructions.
// Datapath: the req is held in the input register, the ALU result in the result
// register, which drives rsp valid; a result waits there while rsp ready is low.
// Throughput: one transfer per cycle while rsp ready is high; between the registers sit
// the operand add or compare, the pc + 4 and branch-target adds, and result selection.
// Reset (synchronous, active high) clears both stage valid bits; payload is not reset.
`default_nettype none

module itype_execute_unit import iteu_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   iteu_req_if.sink   req_if,
   iteu_rsp_if.source rsp_if
);

   // Input stage
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // Result stage
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;

   rsp_payload_type alu_rsp;
   logic            out_load;   // result register takes the input stage
   logic            in_load;    // input register takes a req transfer

   // Result register frees up when empty or when its content transfers this cycle.
   assign out_load = !out_valid_ff || rsp_if.ready;
   // Input register frees up when empty or when it moves into the result register.
   assign req_if.ready = !in_valid_ff || out_load;
   assign in_load      = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff.req_type  <= req_if.req_type;
         in_data_ff.rs_value  <= req_if.rs_value;
         in_data_ff.rt_value  <= req_if.rt_value;
         in_data_ff.immediate <= req_if.immediate;
         in_data_ff.pc_value  <= req_if.pc_value;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= alu_rsp;
      end
   end

   iteu_alu u_alu (
      .req (in_data_ff),
      .rsp (alu_rsp)
   );

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_value = out_data_ff.result_value;
   assign rsp_if.write_result = out_data_ff.write_result;
   assign rsp_if.overflow     = out_data_ff.overflow;
   assign rsp_if.branch_taken = out_data_ff.branch_taken;
   assign rsp_if.next_pc      = out_data_ff.next_pc;

   // An overflowing addi never writes rt.
   a_ovf_no_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff.overflow && out_data_ff.write_result))
      else $error("overflow result marked for write");

   // A taken branch never writes rt.
   a_branch_no_write: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.branch_taken |-> !out_data_ff.write_result)
      else $error("taken branch marked for write");

   // A req transfer always lands in the input stage.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      in_load |=> in_valid_ff)
      else $error("req transfer lost");

   // A filled input stage with a free result stage moves forward.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_load |=> out_valid_ff)
      else $error("input stage did not advance");

endmodule

`default_nettype wire

// ===== bench/itype_execute_unit_tb.sv =====
`default_nettype none

module itype_execute_unit_tb;
   import iteu_pkg::*;

   // Opcode 4'hF is not assigned. The block must still answer it with a plain
   // pc + 4 and no side effects.
   localparam logic [OP_W-1:0] OP_UNUSED = 4'd15;

   localparam int RANDOM_INSTRS = 400;
   // Tail after the last expected result. The pipeline is two stages deep, so
   // this tail catches any stray extra transfer.
   localparam int DRAIN_CYCLES  = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   iteu_req_if req_ch ();
   iteu_rsp_if rsp_ch ();

   itype_execute_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // Instructions waiting to be driven, and the results they must produce,
   // in transfer order.
   req_payload_type pending_instrs[$];
   rsp_payload_type expected_results[$];
   rsp_payload_type golden;

   int total_instrs    = 0;
   int directed_instrs = 0;
   int issued_count    = 0;
   int checked_count   = 0;
   int overflow_count  = 0;
   int taken_count     = 0;
   int write_count     = 0;
   int error_count     = 0;

   // Back-pressure schedule, in percent of cycles spent idle on each side.
   // First third: slow receiver. Second third: slow sender. Last third: no gaps.
   int src_idle_pct;
   int snk_idle_pct;

   always_comb begin
      if (issued_count < total_instrs / 3) begin
         src_idle_pct = 18;
         snk_idle_pct = 87;
      end else if (issued_count < (2 * total_instrs) / 3) begin
         src_idle_pct = 87;
         snk_idle_pct = 18;
      end else begin
         src_idle_pct = 0;
         snk_idle_pct = 0;
      end
   end

   // Expected execute-stage outcome for one I-type instruction.
   function automatic rsp_payload_type predict_itype_result(req_payload_type instr);
      logic [WORD_W-1:0] rs_word;
      logic [WORD_W-1:0] rt_word;
      logic [WORD_W-1:0] sext_imm;
      logic [WORD_W-1:0] zext_imm;
      logic [WORD_W-1:0] seq_pc;
      logic [WORD_W-1:0] target_pc;
      logic [WORD_W-1:0] sum;
      logic              take;
      rsp_payload_type   outcome;

      rs_word   = instr.rs_value;
      rt_word   = instr.rt_value;
      sext_imm  = {{(WORD_W-IMM_W){instr.immediate[IMM_W-1]}}, instr.immediate};
      zext_imm  = {{(WORD_W-IMM_W){1'b0}}, instr.immediate};
      seq_pc    = instr.pc_value + PC_STEP;
      target_pc = seq_pc + (sext_imm << 2);
      sum       = rs_word + sext_imm;
      take      = 1'b0;
      outcome   = '0;

      case (instr.req_type)
         OP_ADDI: begin
            // Signed overflow: operands agree in sign, the sum does not.
            // On overflow nothing is written and the value field stays zero.
            if (rs_word[WORD_W-1] == sext_imm[WORD_W-1] &&
                sum[WORD_W-1] != rs_word[WORD_W-1]) begin
               outcome.overflow = 1'b1;
            end else begin
               outcome.result_value = sum;
               outcome.write_result = 1'b1;
            end
         end
         OP_ADDIU: begin
            outcome.result_value = sum;
            outcome.write_result = 1'b1;
         end
         OP_ANDI: begin
            outcome.result_value = rs_word & zext_imm;
            outcome.write_result = 1'b1;
         end
         OP_ORI: begin
            outcome.result_value = rs_word | zext_imm;
            outcome.write_result = 1'b1;
         end
         OP_XORI: begin
            outcome.result_value = rs_word ^ zext_imm;
            outcome.write_result = 1'b1;
         end
         OP_LUI: begin
            outcome.result_value = {instr.immediate, {(WORD_W-IMM_W){1'b0}}};
            outcome.write_result = 1'b1;
         end
         OP_SLTI: begin
            outcome.result_value = ($signed(rs_word) < $signed(sext_imm)) ? 32'd1 : 32'd0;
            outcome.write_result = 1'b1;
         end
         OP_SLTIU: begin
            // Immediate is sign-extended first, then compared unsigned.
            outcome.result_value = (rs_word < sext_imm) ? 32'd1 : 32'd0;
            outcome.write_result = 1'b1;
         end
         OP_BEQ:  take = (rs_word == rt_word);
         OP_BNE:  take = (rs_word != rt_word);
         OP_BGEZ: take = !rs_word[WORD_W-1];
         OP_BGTZ: take = !rs_word[WORD_W-1] && (rs_word != '0);
         OP_BLEZ: take = rs_word[WORD_W-1] || (rs_word == '0);
         OP_BLTZ: take = rs_word[WORD_W-1];
         // Address only; loads and stores write nothing at this stage.
         OP_MEM:  outcome.result_value = sum;
         default: ;
      endcase

      outcome.branch_taken = take;
      outcome.next_pc      = take ? target_pc : seq_pc;
      return outcome;
   endfunction

   task automatic add_instr(logic [OP_W-1:0] op, logic [WORD_W-1:0] rs,
                            logic [WORD_W-1:0] rt, logic [IMM_W-1:0] imm,
                            logic [WORD_W-1:0] pc);
      req_payload_type instr;
      instr.req_type  = op;
      instr.rs_value  = rs;
      instr.rt_value  = rt;
      instr.immediate = imm;
      instr.pc_value  = pc;
      pending_instrs.push_back(instr);
   endtask

   // Register operand biased toward the signed and unsigned corners.
   function automatic logic [WORD_W-1:0] pick_operand();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return $urandom_range(16);
         5:       return -$urandom_range(16);
         default: return $urandom();
      endcase
   endfunction

   task automatic check_field(string field, logic [WORD_W-1:0] want,
                              logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         error_count++;
      end
   endtask

   // Driver. The prediction is taken at the transfer edge, from the payload
   // that was on the bus when valid and ready met.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_itype_result({req_ch.req_type,
               req_ch.rs_value, req_ch.rt_value, req_ch.immediate, req_ch.pc_value}));
         end
         // A new item may be presented once the bus is free or just transferred.
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_instrs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               req_payload_type nxt;
               nxt = pending_instrs.pop_front();
               req_ch.req_type  <= nxt.req_type;
               req_ch.rs_value  <= nxt.rs_value;
               req_ch.rt_value  <= nxt.rt_value;
               req_ch.immediate <= nxt.immediate;
               req_ch.pc_value  <= nxt.pc_value;
               req_ch.valid     <= 1'b1;
               issued_count++;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing outstanding: result_value=%h next_pc=%h",
                      rsp_ch.result_value, rsp_ch.next_pc);
               error_count++;
            end else begin
               golden = expected_results.pop_front();
               check_field("result_value", golden.result_value, rsp_ch.result_value);
               check_field("write_result", golden.write_result, rsp_ch.write_result);
               check_field("overflow", golden.overflow, rsp_ch.overflow);
               check_field("branch_taken", golden.branch_taken, rsp_ch.branch_taken);
               check_field("next_pc", golden.next_pc, rsp_ch.next_pc);
               checked_count++;
               overflow_count += golden.overflow;
               taken_count    += golden.branch_taken;
               write_count    += golden.write_result;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [OP_W-1:0]   op;
      logic [WORD_W-1:0] rs;
      logic [WORD_W-1:0] rt;
      logic [IMM_W-1:0]  imm;

      req_ch.valid     = 1'b0;
      req_ch.req_type  = '0;
      req_ch.rs_value  = '0;
      req_ch.rt_value  = '0;
      req_ch.immediate = '0;
      req_ch.pc_value  = '0;
      rsp_ch.ready     = 1'b0;

      // Directed corners.
      // addi: positive overflow, negative overflow, mixed signs never overflow
      add_instr(OP_ADDI,  32'h7FFF_FFFF, '0, 16'h0001, 32'h0000_0000);
      add_instr(OP_ADDI,  32'h8000_0000, '0, 16'hFFFF, 32'h0000_1000);
      add_instr(OP_ADDI,  32'h8000_0000, '0, 16'h7FFF, 32'hFFFF_FFFF);
      // addiu wraps silently
      add_instr(OP_ADDIU, 32'h7FFF_FFFF, '0, 16'h0001, 32'h0040_0000);
      add_instr(OP_ADDIU, 32'h0000_0000, '0, 16'h8000, 32'h0040_0004);
      // logic ops zero-extend
      add_instr(OP_ANDI,  32'hFFFF_FFFF, '0, 16'hFFFF, 32'h0040_0008);
      add_instr(OP_ORI,   32'h0000_0000, '0, 16'h8000, 32'h0040_000C);
      add_instr(OP_XORI,  32'hFFFF_FFFF, '0, 16'hFFFF, 32'h0040_0010);
      add_instr(OP_LUI,   32'h1234_5678, '0, 16'hFFFF, 32'h0040_0014);
      // slti signed vs sltiu unsigned against a sign-extended immediate
      add_instr(OP_SLTI,  32'h8000_0000, '0, 16'h0000, 32'h0040_0018);
      add_instr(OP_SLTI,  32'h0000_0000, '0, 16'hFFFF, 32'h0040_001C);
      add_instr(OP_SLTIU, 32'h7FFF_FFFF, '0, 16'hFFFF, 32'h0040_0020);
      add_instr(OP_SLTIU, 32'hFFFF_FFFF, '0, 16'h0000, 32'h0040_0024);
      // branches: target wraps past the top, negative offset, zero edges
      add_instr(OP_BEQ,   32'hDEAD_BEEF, 32'hDEAD_BEEF, 16'h7FFF, 32'hFFFF_FFFC);
      add_instr(OP_BEQ,   32'h0000_0001, 32'h0000_0000, 16'h0010, 32'h0000_0100);
      add_instr(OP_BNE,   32'h0000_0001, 32'h8000_0000, 16'h8000, 32'h0000_0000);
      add_instr(OP_BGEZ,  32'h0000_0000, '0, 16'hFFFF, 32'h0000_0200);
      add_instr(OP_BGTZ,  32'h0000_0000, '0, 16'h0004, 32'h0000_0300);
      add_instr(OP_BGTZ,  32'h7FFF_FFFF, '0, 16'h0004, 32'h0000_0300);
      add_instr(OP_BLEZ,  32'h0000_0000, '0, 16'h0008, 32'h0000_0400);
      add_instr(OP_BLEZ,  32'h0000_0001, '0, 16'h0008, 32'h0000_0400);
      add_instr(OP_BLTZ,  32'h8000_0000, '0, 16'hFFFE, 32'h0000_0500);
      // address calculation wraps, no write
      add_instr(OP_MEM,   32'h0000_0000, '0, 16'hFFFF, 32'h0000_0600);
      add_instr(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      directed_instrs = pending_instrs.size();

      // Random part: corner-biased operands, beq/bne get equal pairs half the time.
      for (int i = 0; i < RANDOM_INSTRS; i++) begin
         op = OP_W'($urandom_range(15));
         rs = pick_operand();
         rt = ($urandom_range(1) == 0) ? rs : pick_operand();
         case ($urandom_range(5))
            0:       imm = 16'h0000;
            1:       imm = 16'hFFFF;
            2:       imm = ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
            default: imm = IMM_W'($urandom());
         endcase
         add_instr(op, rs, rt, imm, $urandom());
      end
      total_instrs = pending_instrs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Everything handed over, then everything answered, then a quiet tail.
      while (pending_instrs.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d result transfers for %0d instructions (%0d directed, all opcodes).",
               checked_count, total_instrs, directed_instrs);
      $display("Seen: %0d addi overflows, %0d taken branches, %0d register writes.",
               overflow_count, taken_count, write_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run under the worst stall schedule.
   initial begin
      #(8 * 200000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
